FILE: design/hpsu_pkg.sv
// ----------------------------------------------------------------------------
// hpsu_pkg: shared types and constants of the hex PDU septet unpacker
// Holds the character decode rule, the queue command format and defaults.
// ----------------------------------------------------------------------------
package hpsu_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] CHAR_NINE    = 8'd57;
  localparam logic [7:0] ALPHA_OFFSET = 8'd55;
  localparam logic [7:0] DIGIT_OFFSET = 8'd48;
  localparam logic [6:0] SEPT_MASK    = 7'd127;

  // One octet of user data on its way from the front to the back.
  typedef struct packed {
    logic [7:0] octet;   // decoded octet
    logic [2:0] shift;   // buffered bits ahead of this octet (septet mode)
    logic       binary;  // octet mode for this field
    logic [1:0] cnt;     // results this octet produces (1 or 2)
    logic       last;    // final result of the field is among them
  } cmd_t;

  // Maps a hex character to its digit value; non-hex input follows the same rule.
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c > CHAR_NINE) begin
      v = c - ALPHA_OFFSET;
    end else begin
      v = c - DIGIT_OFFSET;
    end
    return v;
  endfunction

endpackage

FILE: design/hpsu_front.sv
// ----------------------------------------------------------------------------
// hpsu_front: character intake and field tracking
// Pairs hex digits into octets, takes the length octet and counts results.
// ----------------------------------------------------------------------------
module hpsu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          char_valid,
  output logic          char_ready,
  input  logic [7:0]    hex_char,
  input  logic          start_req,
  input  logic          binary_mode,
  output logic          cmd_valid,
  output hpsu_pkg::cmd_t cmd,
  input  logic          cmd_ready
);
  import hpsu_pkg::*;

  logic       nibble_phase, nibble_phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       header_done, header_done_next;
  logic       active, active_next;
  logic [7:0] remaining, remaining_next;
  logic [2:0] bit_count, bit_count_next;
  logic       mode_bit, mode_bit_next;

  logic       accept;
  logic       s_phase, s_hdr, s_active, s_mode;
  logic [7:0] s_rem;
  logic [2:0] s_bc;
  logic [7:0] dv, octet;
  logic [3:0] bc8;
  logic       two;
  logic [7:0] rem_dec;

  assign char_ready = cmd_ready;
  assign accept     = char_valid && char_ready;

  always_comb begin
    // A start clears the field state before the character is used.
    s_active = start_req ? 1'b1 : active;
    s_phase  = start_req ? 1'b0 : nibble_phase;
    s_hdr    = start_req ? 1'b0 : header_done;
    s_mode   = start_req ? binary_mode : mode_bit;
    s_rem    = start_req ? 8'd0 : remaining;
    s_bc     = start_req ? 3'd0 : bit_count;

    dv    = digit_value(hex_char);
    octet = {high_nibble, 4'b0000} + dv;

    bc8     = {1'b0, s_bc} + 4'd8;
    two     = !s_mode && (bc8 >= 4'd14) && (s_rem >= 8'd2);
    rem_dec = s_rem - (two ? 8'd2 : 8'd1);

    nibble_phase_next = s_phase;
    high_nibble_next  = high_nibble;
    header_done_next  = s_hdr;
    active_next       = s_active;
    remaining_next    = s_rem;
    bit_count_next    = s_bc;
    mode_bit_next     = s_mode;

    cmd_valid  = 1'b0;
    cmd.octet  = octet;
    cmd.shift  = s_bc;
    cmd.binary = s_mode;
    cmd.cnt    = two ? 2'd2 : 2'd1;
    cmd.last   = (rem_dec == 8'd0);

    if (s_active) begin
      if (!s_phase) begin
        high_nibble_next  = dv[3:0];
        nibble_phase_next = 1'b1;
      end else begin
        nibble_phase_next = 1'b0;
        if (!s_hdr) begin
          header_done_next = 1'b1;
          remaining_next   = octet;
          active_next      = (octet != 8'd0);
        end else begin
          cmd_valid      = accept;
          remaining_next = rem_dec;
          active_next    = (rem_dec != 8'd0);
          if (!s_mode) begin
            bit_count_next = two ? 3'((bc8 - 4'd14)) : 3'((bc8 - 4'd7));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_phase <= 1'b0;
      header_done  <= 1'b0;
      active       <= 1'b0;
      remaining    <= 8'd0;
      bit_count    <= 3'd0;
      mode_bit     <= 1'b0;
    end else if (accept) begin
      nibble_phase <= nibble_phase_next;
      header_done  <= header_done_next;
      active       <= active_next;
      remaining    <= remaining_next;
      bit_count    <= bit_count_next;
      mode_bit     <= mode_bit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      high_nibble <= high_nibble_next;
    end
  end

endmodule

FILE: design/hpsu_queue.sv
// ----------------------------------------------------------------------------
// hpsu_queue: short command queue between front and back
// Register-based FIFO; the head entry is presented without a bubble.
// ----------------------------------------------------------------------------
module hpsu_queue #(
  parameter int unsigned DEPTH = hpsu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  hpsu_pkg::cmd_t push_cmd,
  output logic           head_valid,
  output hpsu_pkg::cmd_t head_cmd,
  input  logic           pop
);
  import hpsu_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: design/hpsu_back.sv
// ----------------------------------------------------------------------------
// hpsu_back: septet extraction and result register
// Merges each octet into the bit buffer and emits one or two results.
// ----------------------------------------------------------------------------
module hpsu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  hpsu_pkg::cmd_t head_cmd,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_ready,
  output logic [7:0]     data,
  output logic           last
);
  import hpsu_pkg::*;

  logic [14:0] bit_buffer;
  logic        sel;
  logic        load, fire, is_final;
  logic [14:0] keep_mask, merged;
  logic [7:0]  result;

  assign load      = !res_valid || res_ready;
  assign fire      = head_valid && load;
  assign is_final  = sel || (head_cmd.cnt == 2'd1);
  assign pop       = fire && is_final;

  // Only the bits below the shift are live; older leftovers are dropped.
  assign keep_mask = (15'd1 << head_cmd.shift) - 15'd1;
  assign merged    = (bit_buffer & keep_mask) | (15'(head_cmd.octet) << head_cmd.shift);

  always_comb begin
    if (head_cmd.binary) begin
      result = head_cmd.octet;
    end else if (sel) begin
      result = {1'b0, merged[13:7] & SEPT_MASK};
    end else begin
      result = {1'b0, merged[6:0] & SEPT_MASK};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      sel       <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= head_valid;
      end
      if (fire) begin
        sel <= !is_final;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      data <= result;
      last <= head_cmd.last && is_final;
    end
    if (pop && !head_cmd.binary) begin
      bit_buffer <= (head_cmd.cnt == 2'd2) ? (merged >> 14) : (merged >> 7);
    end
  end

`ifndef SYNTHESIS
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (head_cmd.cnt == 2'd1 || head_cmd.cnt == 2'd2))
    else $error("queued octet carries no result");
  a_second_half: assert property (@(posedge clk) disable iff (rst)
    sel |-> (head_valid && head_cmd.cnt == 2'd2))
    else $error("second result pending without a two-result octet");
  a_septet_range: assert property (@(posedge clk) disable iff (rst)
    (fire && !head_cmd.binary) |=> !data[7])
    else $error("septet result exceeds seven bits");
`endif

endmodule

FILE: design/hex_pdu_septet_unpacker_core.sv
// ----------------------------------------------------------------------------
// hex_pdu_septet_unpacker_core: hex-text SMS user-data unpacker
// Decodes hex characters into octets and emits septets or raw octets.
// ----------------------------------------------------------------------------
// Results: a result is registered on data/last once the low digit that completes
//   its octet has passed through the queue; a second septet of that octet follows.
// Throughput: one character per cycle while the queue has room; an octet needs two
//   characters and yields at most two results, so the result register keeps up.
// Reset (rst, synchronous): the block is idle until a character with start_req,
//   the queue is empty and no result is pending.
module hex_pdu_septet_unpacker_core #(
  parameter int unsigned QUEUE_DEPTH = hpsu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] hex_char,
  input  logic       start_req,
  input  logic       binary_mode,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] data,
  output logic       last
);
  import hpsu_pkg::*;

  // The front accepts a character in every cycle in which the queue has room.
  // It tracks the digit phase, the length octet, the remaining result count
  // and the septet bit count, and hands each data octet to the queue as a
  // command that already says how many results it yields and whether the
  // field ends with it.
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  // The back holds the septet bit buffer and the result register. It removes
  // a command from the queue once its last result has gone into the register.
  logic head_valid, pop;
  cmd_t head_cmd;

  hpsu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .hex_char    (hex_char),
    .start_req   (start_req),
    .binary_mode (binary_mode),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_ready   (cmd_ready)
  );

  hpsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .push_ready (cmd_ready),
    .push_cmd   (cmd),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  hpsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .data       (data),
    .last       (last)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the hex PDU septet unpacker
// Streams hex text fields through the character port and checks every
// transfer on the result port against an in-bench model of the unpacker.
// ----------------------------------------------------------------------------
module tb_top;

  // One result of the block: a septet code or a raw octet, plus the end mark.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } unpacked_t;

  // One row of the directed table. Rows with typed set carry their own
  // expected results; the others are checked against the model below.
  typedef struct {
    logic [7:0] ch;
    logic       sr;
    logic       bm;
    bit         typed;
    int         n;
    unpacked_t  r0;
    unpacked_t  r1;
  } row_t;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 410;
  localparam int CALM_ITEMS   = 340;

  // Character decode: anything above the '9' code is taken as a letter digit.
  localparam logic [7:0] NINE_CODE   = 8'd57;
  localparam logic [7:0] LETTER_BASE = 8'd55;
  localparam logic [7:0] DIGIT_BASE  = 8'd48;

  logic       clk;
  logic       rst;
  logic       char_valid;
  logic       char_ready;
  logic [7:0] hex_char;
  logic       start_req;
  logic       binary_mode;
  logic       res_valid;
  logic       res_ready;
  logic [7:0] data;
  logic       last;

  // Model state of the unpacker.
  logic        st_phase;    // 0 = next character is a high digit
  logic [7:0]  st_high;
  logic        st_hdr;      // length octet seen
  logic        st_active;
  logic [7:0]  st_remain;
  logic [14:0] st_bits;
  logic [3:0]  st_nbits;
  logic        st_binary;

  unpacked_t unpacked_q[$];  // results still owed by the block, oldest first
  row_t      dir_tab[$];
  row_t      cur_row;        // row behind the character now offered
  row_t      no_row;

  int err_cnt;
  int cycles;
  int items;
  int gap_pct;
  bit calm;                  // set near the end: no idling on either side

  hex_pdu_septet_unpacker_core DUT (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .hex_char   (hex_char),
    .start_req  (start_req),
    .binary_mode(binary_mode),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .data       (data),
    .last       (last)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Model of the block
  // --------------------------------------------------------------------------

  function automatic logic [7:0] digit_of(input logic [7:0] c);
    if (c > NINE_CODE) begin
      return c - LETTER_BASE;
    end
    return c - DIGIT_BASE;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    if (v < 4'd10) begin
      return "0" + v;
    end
    return "A" + v - 8'd10;
  endfunction

  // Applies one accepted character to the model and returns the results it
  // causes (zero, one or two).
  task automatic unpack_char(input logic [7:0] c, input logic s, input logic b,
                             output int n, output unpacked_t r0, output unpacked_t r1);
    logic [7:0] oct;
    n  = 0;
    r0 = '0;
    r1 = '0;
    // A start throws away whatever field was in progress.
    if (s) begin
      st_phase  = 1'b0;
      st_high   = '0;
      st_hdr    = 1'b0;
      st_active = 1'b1;
      st_remain = '0;
      st_bits   = '0;
      st_nbits  = '0;
      st_binary = b;
    end
    if (!st_active) begin
      return;
    end
    if (!st_phase) begin
      st_high  = digit_of(c);
      st_phase = 1'b1;
      return;
    end
    st_phase = 1'b0;
    oct = (st_high << 4) + digit_of(c);
    // The first octet of a field is its length; zero ends the field at once.
    if (!st_hdr) begin
      st_hdr    = 1'b1;
      st_remain = oct;
      if (oct == 8'd0) begin
        st_active = 1'b0;
      end
      return;
    end
    if (st_binary) begin
      st_remain = st_remain - 8'd1;
      r0.data   = oct;
      r0.last   = (st_remain == 8'd0);
      n = 1;
    end else begin
      // Septets are taken LSB first; an octet can complete two of them.
      st_bits  = st_bits | ({7'd0, oct} << st_nbits[2:0]);
      st_nbits = st_nbits + 4'd8;
      while (st_nbits >= 4'd7 && st_remain != 8'd0 && n < 2) begin
        st_remain = st_remain - 8'd1;
        if (n == 0) begin
          r0.data = {1'b0, st_bits[6:0]};
          r0.last = (st_remain == 8'd0);
        end else begin
          r1.data = {1'b0, st_bits[6:0]};
          r1.last = (st_remain == 8'd0);
        end
        st_bits  = st_bits >> 7;
        st_nbits = st_nbits - 4'd7;
        n++;
      end
    end
    if (st_remain == 8'd0) begin
      st_active = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: both ports are sampled at the rising edge. A result can only
  // show up after the character that causes it has passed through the queue,
  // so checking before predicting within the same edge is safe.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : port_monitor
    int        n;
    unpacked_t r0;
    unpacked_t r1;
    unpacked_t got;
    unpacked_t want;
    if (!rst) begin
      if (res_valid && res_ready) begin
        got.data = data;
        got.last = last;
        if (unpacked_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("unexpected result transfer: data=%h last=%b", got.data, got.last);
          end
        end else begin
          want = unpacked_q.pop_front();
          if (got.data !== want.data || got.last !== want.last) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("result mismatch: expected data=%h last=%b, got data=%h last=%b",
                       want.data, want.last, got.data, got.last);
            end
          end
        end
      end
      if (char_valid && char_ready) begin
        unpack_char(hex_char, start_req, binary_mode, n, r0, r1);
        // Typed rows keep the model's state moving but use their own values.
        if (cur_row.typed) begin
          n  = cur_row.n;
          r0 = cur_row.r0;
          r1 = cur_row.r1;
        end
        if (n > 0) begin
          unpacked_q.push_back(r0);
        end
        if (n > 1) begin
          unpacked_q.push_back(r1);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: ready drops in random bursts between open stretches, and
  // stays high once the run is in its calm part.
  // --------------------------------------------------------------------------
  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        res_ready = 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        res_ready = 1'b1;
        repeat ($urandom_range(0, 30)) @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Character side
  // --------------------------------------------------------------------------

  // Offers one character, possibly after an idle burst, and returns at the
  // edge of its transfer. Valid stays up until the next falling edge, so the
  // caller must either offer a new character or lower valid there.
  task automatic send_char(input logic [7:0] c, input logic s, input logic b,
                           input row_t row);
    int gap;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      char_valid  = 1'b0;
      hex_char    = 8'($urandom_range(0, 255));
      start_req   = 1'($urandom_range(0, 1));
      binary_mode = 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cur_row     = row;
    hex_char    = c;
    start_req   = s;
    binary_mode = b;
    char_valid  = 1'b1;
    do @(posedge clk); while (!char_ready);
  endtask

  // Holds the sender back until every owed result has come out.
  task automatic drain();
    @(negedge clk);
    char_valid = 1'b0;
    while (unpacked_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Sends one user-data field: the length octet and then enough random
  // octets for len results. A broken field is cut short at a random point,
  // and the next start has to recover from it.
  task automatic send_field(input logic bin, input logic [7:0] len, input bit cut);
    int         noct;
    int         nchar;
    logic [7:0] oct;
    logic [7:0] c;
    noct  = bin ? int'(len) : (int'(len) * 7 + 7) / 8;
    nchar = 2 * (noct + 1);
    if (cut) begin
      nchar = $urandom_range(1, nchar);
    end
    for (int k = 0; k < nchar; k++) begin
      if (k % 2 == 0) begin
        oct = (k == 0) ? len : 8'($urandom_range(0, 255));
        c   = hex_digit(oct[7:4]);
      end else begin
        c   = hex_digit(oct[3:0]);
      end
      // Now and then a non-hex byte, decoded by the same rule.
      if ($urandom_range(0, 15) == 0) begin
        c = 8'($urandom_range(0, 255));
      end
      send_char(c, k == 0, (k == 0) ? bin : 1'($urandom_range(0, 1)), no_row);
      items++;
      // The tail of the run goes without idling on either side.
      if (items >= CALM_ITEMS) begin
        calm = 1'b1;
      end
    end
    // Stray characters after the end of a field are ignored by the block.
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_char(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), no_row);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int         fidx;
    logic       bin;
    logic [7:0] len;
    bit         cut;

    char_valid  = 1'b0;
    hex_char    = '0;
    start_req   = 1'b0;
    binary_mode = 1'b0;
    rst         = 1'b1;
    err_cnt     = 0;
    cycles      = 0;
    items       = 0;
    calm        = 1'b0;
    gap_pct     = 20;
    no_row      = '{8'h00, 1'b0, 1'b0, 1'b0, 0, '0, '0};
    cur_row     = no_row;
    st_phase    = 1'b0;
    st_high     = '0;
    st_hdr      = 1'b0;
    st_active   = 1'b0;
    st_remain   = '0;
    st_bits     = '0;
    st_nbits    = '0;
    st_binary   = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table. An idle character after reset is dropped.
    dir_tab.push_back('{"A", 1'b0, 1'b0, 1'b1, 0, '0, '0});
    // Binary field, restarted while waiting for its first low digit.
    dir_tab.push_back('{"0", 1'b1, 1'b1, 1'b1, 0, '0, '0});
    dir_tab.push_back('{"0", 1'b1, 1'b1, 1'b1, 0, '0, '0});
    dir_tab.push_back('{"2", 1'b0, 1'b0, 1'b1, 0, '0, '0});
    // High digit alone emits nothing; binary_mode is ignored outside a start.
    dir_tab.push_back('{"F", 1'b0, 1'b1, 1'b1, 0, '0, '0});
    dir_tab.push_back('{"F", 1'b0, 1'b0, 1'b1, 1, '{8'hFF, 1'b0}, '0});
    // The extreme bytes as digits: the model works out the final octet.
    dir_tab.push_back('{8'h00, 1'b0, 1'b0, 1'b1, 0, '0, '0});
    dir_tab.push_back('{8'hFF, 1'b0, 1'b0, 1'b0, 0, '0, '0});
    // After the last octet the field is over, so this is dropped.
    dir_tab.push_back('{"7", 1'b0, 1'b0, 1'b1, 0, '0, '0});
    // A zero length ends the field without any result.
    dir_tab.push_back('{"0", 1'b1, 1'b0, 1'b1, 0, '0, '0});
    dir_tab.push_back('{"0", 1'b0, 1'b0, 1'b1, 0, '0, '0});
    // Septet field of length 8 over seven all-ones octets: one septet per
    // octet, until the seventh completes the last two at once.
    dir_tab.push_back('{"0", 1'b1, 1'b0, 1'b1, 0, '0, '0});
    dir_tab.push_back('{"8", 1'b0, 1'b0, 1'b1, 0, '0, '0});
    for (int k = 1; k <= 7; k++) begin
      dir_tab.push_back('{"F", 1'b0, 1'b0, 1'b1, 0, '0, '0});
      dir_tab.push_back('{"F", 1'b0, 1'b0, 1'b1, (k == 7) ? 2 : 1,
                          '{8'h7F, 1'b0}, '{8'h7F, 1'b1}});
    end

    foreach (dir_tab[i]) begin
      send_char(dir_tab[i].ch, dir_tab[i].sr, dir_tab[i].bm, dir_tab[i]);
    end
    drain();

    // Random fields: mostly well-formed with short lengths, a few cut short,
    // some empty, and one very long septet field.
    fidx = 0;
    while (items < RANDOM_ITEMS) begin
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
      if (fidx == 10) begin
        drain();
      end
      bin = 1'($urandom_range(0, 1));
      cut = ($urandom_range(0, 7) == 0);
      if (fidx == 4) begin
        bin = 1'b0;
        len = 8'($urandom_range(128, 180));
      end else if ($urandom_range(0, 9) == 0) begin
        len = 8'd0;
      end else begin
        len = 8'($urandom_range(1, 20));
      end
      send_field(bin, len, cut);
      fidx++;
    end

    drain();
    repeat (20) @(negedge clk);
    if (err_cnt == 0 && unpacked_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/hpsu_pkg.sv
design/hpsu_front.sv
design/hpsu_queue.sv
design/hpsu_back.sv
design/hex_pdu_septet_unpacker_core.sv
verif/tb_top.sv
